/* sv/lfde_pkg.sv */
// shared types, constants and crc helper for the log frame delta encoder
package lfde_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [2:0] REG_MAGIC0 = 3'd0;
  localparam logic [2:0] REG_MAGIC1 = 3'd1;
  localparam logic [2:0] REG_KEY    = 3'd2;
  localparam logic [2:0] REG_DELTA  = 3'd3;
  localparam logic [2:0] REG_IVAL   = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;

  typedef struct packed {
    logic        hdr;
    logic        key;
    logic        pl;
    logic        last;
    logic [15:0] seq;
    logic [31:0] tfield;
    logic [31:0] sample;
  } job_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* sv/lfde_sample_mem.sv */
// previous sample store, read-first with registered read and per-entry valid bits
module lfde_sample_mem #(
  parameter int DEPTH = 21,
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic          wr_en,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0]      mem [DEPTH];
  logic [DEPTH-1:0] vbits;
  logic [31:0]      rd_q;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q <= mem[addr];
    end
    if (wr_en) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (rd_en) rd_vld <= vbits[addr];
      if (wr_en) vbits[addr] <= 1'b1;
    end
  end

  assign rdata = rd_vld ? rd_q : 32'h0;

endmodule

/* sv/lfde_quant.sv */
// six stage float subtract, multiply by scale and int16 truncation
module lfde_quant (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] cur,
  input  logic [31:0] prev,
  input  logic [31:0] scale,
  output logic [15:0] q
);

  // stage 1: unpack, order by magnitude, align
  logic [31:0] nb, lop, sop;
  logic        a_nan, a_inf, b_nan, b_inf, swap;
  logic [7:0]  el, es, dexp;
  logic [23:0] ml, ms;
  logic [26:0] yv, ysh;
  logic [53:0] yfull;
  logic        stk;

  logic        r1_sign, r1_sub, r1_nan, r1_inf, r1_isgn;
  logic [7:0]  r1_e;
  logic [26:0] r1_x, r1_y;

  assign nb    = {~prev[31], prev[30:0]};
  assign a_nan = (cur[30:23] == 8'hFF) && (cur[22:0] != 23'h0);
  assign a_inf = (cur[30:23] == 8'hFF) && (cur[22:0] == 23'h0);
  assign b_nan = (nb[30:23] == 8'hFF) && (nb[22:0] != 23'h0);
  assign b_inf = (nb[30:23] == 8'hFF) && (nb[22:0] == 23'h0);
  assign swap  = cur[30:0] < nb[30:0];
  assign lop   = swap ? nb : cur;
  assign sop   = swap ? cur : nb;
  assign el    = (lop[30:23] == 8'h0) ? 8'd1 : lop[30:23];
  assign es    = (sop[30:23] == 8'h0) ? 8'd1 : sop[30:23];
  assign ml    = {lop[30:23] != 8'h0, lop[22:0]};
  assign ms    = {sop[30:23] != 8'h0, sop[22:0]};
  assign dexp  = el - es;
  assign yv    = {ms, 3'b000};
  assign yfull = {yv, 27'h0} >> dexp;

  always_comb begin
    if (dexp >= 8'd27) begin
      ysh = '0;
      stk = |ms;
    end else begin
      ysh = yfull[53:27];
      stk = |yfull[26:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_sign <= lop[31];
      r1_sub  <= lop[31] ^ sop[31];
      r1_e    <= el;
      r1_x    <= {ml, 3'b000};
      r1_y    <= {ysh[26:1], ysh[0] | stk};
      r1_nan  <= a_nan | b_nan | (a_inf & b_inf & (cur[31] != nb[31]));
      r1_inf  <= a_inf | b_inf;
      r1_isgn <= a_inf ? cur[31] : nb[31];
    end
  end

  // stage 2: add or subtract, leading zero count
  logic [27:0] sum;
  logic [4:0]  lz1;
  logic [27:0] r2_sum;
  logic [4:0]  r2_lz;
  logic [7:0]  r2_e;
  logic        r2_sign, r2_nan, r2_inf, r2_isgn;

  assign sum = r1_sub ? ({1'b0, r1_x} - {1'b0, r1_y}) : ({1'b0, r1_x} + {1'b0, r1_y});

  always_comb begin
    lz1 = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (sum[i]) lz1 = 5'(26 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r2_sum  <= sum;
      r2_lz   <= lz1;
      r2_e    <= r1_e;
      r2_sign <= r1_sign;
      r2_nan  <= r1_nan;
      r2_inf  <= r1_inf;
      r2_isgn <= r1_isgn;
    end
  end

  // stage 3: normalize and round the difference
  logic [7:0]  elim;
  logic [4:0]  sh;
  logic [26:0] nrm;
  logic [8:0]  e9, e9f;
  logic        up;
  logic [24:0] m25;
  logic [23:0] mf;
  logic        ovf;

  logic        d_sign, d_nan, d_inf, d_zero;
  logic [7:0]  d_e;
  logic [23:0] d_m;

  assign elim = r2_e - 8'd1;

  always_comb begin
    sh = ({3'b000, r2_lz} < elim) ? r2_lz : elim[4:0];
    if (r2_sum[27]) begin
      nrm = {r2_sum[27:2], r2_sum[1] | r2_sum[0]};
      e9  = {1'b0, r2_e} + 9'd1;
    end else begin
      nrm = r2_sum[26:0] << sh;
      e9  = {1'b0, r2_e} - {4'b0, sh};
    end
    up  = nrm[2] & (nrm[1] | nrm[0] | nrm[3]);
    m25 = {1'b0, nrm[26:3]} + {24'h0, up};
    if (m25[24]) begin
      mf  = m25[24:1];
      e9f = e9 + 9'd1;
    end else begin
      mf  = m25[23:0];
      e9f = e9;
    end
    ovf = e9f >= 9'd255;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_nan  <= r2_nan;
      d_inf  <= !r2_nan && (r2_inf || ovf);
      d_sign <= r2_inf ? r2_isgn : r2_sign;
      d_zero <= !r2_nan && !r2_inf && (r2_sum == 28'h0);
      d_e    <= e9f[7:0];
      d_m    <= (r2_sum == 28'h0) ? 24'h0 : mf;
    end
  end

  // stage 4: multiply by the scale
  logic        s_nan, s_inf, s_zero;
  logic [7:0]  sce;
  logic [23:0] scm;
  logic [47:0] p_prod;
  logic [8:0]  p_exp;
  logic        p_sign, p_nan, p_inf;

  assign s_nan  = (scale[30:23] == 8'hFF) && (scale[22:0] != 23'h0);
  assign s_inf  = (scale[30:23] == 8'hFF) && (scale[22:0] == 23'h0);
  assign s_zero = scale[30:0] == 31'h0;
  assign sce    = (scale[30:23] == 8'h0) ? 8'd1 : scale[30:23];
  assign scm    = {scale[30:23] != 8'h0, scale[22:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      p_prod <= d_m * scm;
      p_exp  <= {1'b0, d_e} + {1'b0, sce};
      p_sign <= d_sign ^ scale[31];
      p_nan  <= d_nan | s_nan | (d_inf & s_zero) | (s_inf & d_zero);
      p_inf  <= d_inf | s_inf;
    end
  end

  // stage 5: normalize the product
  logic [5:0]  lz2;
  logic [47:0] n5;
  logic signed [10:0] k5;
  logic        r5_zero, r5_sign, r5_nan, r5_inf;

  always_comb begin
    lz2 = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (p_prod[i]) lz2 = 6'(47 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n5      <= p_prod << lz2;
      k5      <= $signed({2'b00, p_exp}) - $signed({5'b0, lz2}) - 11'sd253;
      r5_zero <= p_prod == 48'h0;
      r5_sign <= p_sign;
      r5_nan  <= p_nan;
      r5_inf  <= p_inf;
    end
  end

  // stage 6: round to single and truncate to int16
  logic        up6;
  logic [24:0] m6;
  logic [23:0] mn;
  logic signed [10:0] k6;
  logic [4:0]  rsh;
  logic [23:0] mag;
  logic [15:0] qv;

  always_comb begin
    up6 = n5[23] & ((|n5[22:0]) | n5[24]);
    m6  = {1'b0, n5[47:24]} + {24'h0, up6};
    mn  = m6[24] ? m6[24:1] : m6[23:0];
    k6  = k5 + $signed({10'b0, m6[24]});
    rsh = 5'd23 - k6[4:0];
    mag = mn >> rsh;
    if (r5_nan) begin
      qv = 16'h0000;
    end else if (r5_inf || (!r5_zero && k6 >= 11'sd15)) begin
      qv = r5_sign ? 16'h8000 : 16'h7FFF;
    end else if (r5_zero || k6 < 11'sd0) begin
      qv = 16'h0000;
    end else begin
      qv = r5_sign ? (16'h0 - mag[15:0]) : mag[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= qv;
    end
  end

endmodule

/* sv/lfde_framer.sv */
// frame byte sequencer with running crc and output register
module lfde_framer
  import lfde_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  job_t        job,
  input  logic [15:0] q,
  input  logic [7:0]  magic_first,
  input  logic [7:0]  magic_second,
  input  logic [7:0]  key_type_code,
  input  logic [7:0]  delta_type_code,
  output logic        take,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);

  localparam int NUM_SLOTS = 15;
  localparam logic [3:0] SLOT_MAGIC0  = 4'd0;
  localparam logic [3:0] SLOT_MAGIC1  = 4'd1;
  localparam logic [3:0] SLOT_TYPE    = 4'd2;
  localparam logic [3:0] SLOT_SEQ0    = 4'd3;
  localparam logic [3:0] SLOT_SEQ1    = 4'd4;
  localparam logic [3:0] SLOT_TIME0   = 4'd5;
  localparam logic [3:0] SLOT_TIME1   = 4'd6;
  localparam logic [3:0] SLOT_TIME2   = 4'd7;
  localparam logic [3:0] SLOT_TIME3   = 4'd8;
  localparam logic [3:0] SLOT_DATA0   = 4'd9;
  localparam logic [3:0] SLOT_DATA1   = 4'd10;
  localparam logic [3:0] SLOT_DATA2   = 4'd11;
  localparam logic [3:0] SLOT_DATA3   = 4'd12;
  localparam logic [3:0] SLOT_CRC_LO  = 4'd13;
  localparam logic [3:0] SLOT_CRC_HI  = 4'd14;

  job_t                 jreg;
  logic [15:0]          qreg;
  logic [NUM_SLOTS-1:0] rem, rem_clr, mask;
  logic [15:0]          crc;
  logic [3:0]           sel;
  logic [7:0]           byte_sel;
  logic [31:0]          data_word;
  logic                 emit;

  always_comb begin
    mask = '0;
    if (job.hdr) begin
      mask[4:0] = 5'h1F;
      mask[6:5] = 2'b11;
      if (job.key) mask[8:7] = 2'b11;
    end
    if (job.key) mask[12:9] = 4'hF;
    else if (job.pl) mask[10:9] = 2'b11;
    if (job.last) mask[14:13] = 2'b11;
  end

  always_comb begin
    sel = SLOT_CRC_HI;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (rem[i]) sel = 4'(i);
    end
  end

  assign data_word = jreg.key ? jreg.sample : {16'h0, qreg};

  always_comb begin
    case (sel)
      SLOT_MAGIC0: byte_sel = magic_first;
      SLOT_MAGIC1: byte_sel = magic_second;
      SLOT_TYPE:   byte_sel = jreg.key ? key_type_code : delta_type_code;
      SLOT_SEQ0:   byte_sel = jreg.seq[7:0];
      SLOT_SEQ1:   byte_sel = jreg.seq[15:8];
      SLOT_TIME0:  byte_sel = jreg.tfield[7:0];
      SLOT_TIME1:  byte_sel = jreg.tfield[15:8];
      SLOT_TIME2:  byte_sel = jreg.tfield[23:16];
      SLOT_TIME3:  byte_sel = jreg.tfield[31:24];
      SLOT_DATA0:  byte_sel = data_word[7:0];
      SLOT_DATA1:  byte_sel = data_word[15:8];
      SLOT_DATA2:  byte_sel = data_word[23:16];
      SLOT_DATA3:  byte_sel = data_word[31:24];
      SLOT_CRC_LO: byte_sel = crc[7:0];
      SLOT_CRC_HI: byte_sel = crc[15:8];
      default:     byte_sel = 8'h00;
    endcase
  end

  assign emit    = (rem != '0) && (!out_valid || out_ready);
  assign rem_clr = rem & ~(NUM_SLOTS'(1) << sel);
  assign take    = (rem == '0) || (emit && (rem_clr == '0));

  always_ff @(posedge clk) begin
    if (take && job_valid) begin
      jreg <= job;
      qreg <= q;
    end
    if (emit) begin
      frame_byte <= byte_sel;
      frame_end  <= sel == SLOT_CRC_HI;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem       <= '0;
      crc       <= CRC_INIT;
      out_valid <= 1'b0;
    end else begin
      if (take) rem <= job_valid ? mask : '0;
      else if (emit) rem <= rem_clr;
      if (emit) begin
        if (sel == SLOT_MAGIC0) crc <= crc_byte(CRC_INIT, byte_sel);
        else if (sel < SLOT_CRC_LO) crc <= crc_byte(crc, byte_sel);
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_end_spacing: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && frame_end |=> !(out_valid && frame_end))
    else $error("two frame ends in consecutive beats");

endmodule

/* sv/log_frame_delta_encoder.sv */
// top level: record sequencing, sample store, quantizer pipeline and frame output
//
//   channel | beat contents                  | handshake
//   in      | sample_bits, time_ms           | in_valid / in_ready
//   cfg     | cfg_index, cfg_data            | cfg_valid / cfg_ready
//   out     | frame_byte, frame_end          | out_valid / out_ready
//
// a sample is accepted each cycle the pipeline moves; its first byte appears after the
// pipeline and the framer's output register, then it holds the byte output for 0 to 15
// bytes, one per cycle while out is not stalled; the byte sequencer sets the sustained
// rate: with 21 channels about 2.4 bytes per sample in delta frames and 4.5 in key frames
// a stall on out holds the 7 stage pipeline; in_ready drops while its last stage is full
// and the sequencer still has bytes left; reset clears counters, crc and store valid bits
module log_frame_delta_encoder
  import lfde_pkg::*;
#(
  parameter int CHANNELS = 21,
  parameter int DELTA_CHANNELS = 21
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  input  logic [31:0] time_ms,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        frame_end
);

  localparam int ChW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int QLAT = 6;
  localparam int LAST = QLAT;

  logic [7:0]  magic_first, magic_second, key_type_code, delta_type_code;
  logic [15:0] key_interval;
  logic [31:0] delta_scale_bits;

  logic [ChW-1:0] ch;
  logic           key_active;
  logic [15:0]    rec_cnt, seq;
  logic [31:0]    prev_time;

  logic           adv, acc, is0, key_now, take;
  logic [31:0]    tdiff;
  logic [15:0]    tsat;
  logic [16:0]    rec_inc;
  job_t           job0;
  job_t           jobs [QLAT+1];
  logic [LAST:0]  vld;
  logic [31:0]    prev_sample;
  logic [15:0]    q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magic_first      <= 8'h00;
      magic_second     <= 8'h00;
      key_type_code    <= 8'h00;
      delta_type_code  <= 8'h01;
      key_interval     <= 16'd10;
      delta_scale_bits <= 32'h42C8_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAGIC0: magic_first      <= cfg_data[7:0];
        REG_MAGIC1: magic_second     <= cfg_data[7:0];
        REG_KEY:    key_type_code    <= cfg_data[7:0];
        REG_DELTA:  delta_type_code  <= cfg_data[7:0];
        REG_IVAL:   key_interval     <= cfg_data[15:0];
        REG_SCALE:  delta_scale_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  assign adv      = !vld[LAST] || take;
  assign in_ready = adv;
  assign acc      = in_valid && in_ready;
  assign is0      = ch == '0;
  assign key_now  = is0 ? (rec_cnt == 16'h0) : key_active;
  assign tdiff    = time_ms - prev_time;
  assign rec_inc  = {1'b0, rec_cnt} + 17'd1;

  always_comb begin
    if (!tdiff[31] && (tdiff > 32'd32767)) tsat = 16'h7FFF;
    else if (tdiff[31] && (tdiff < 32'hFFFF_8000)) tsat = 16'h8000;
    else tsat = tdiff[15:0];
  end

  always_comb begin
    job0.hdr    = is0;
    job0.key    = key_now;
    job0.pl     = key_now || ({{(6-ChW){1'b0}}, ch} < 6'(DELTA_CHANNELS));
    job0.last   = ch == ChW'(CHANNELS - 1);
    job0.seq    = seq;
    job0.tfield = key_now ? time_ms : {16'h0, tsat};
    job0.sample = sample_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ch         <= '0;
      key_active <= 1'b0;
      rec_cnt    <= 16'h0;
      seq        <= 16'h0;
      prev_time  <= 32'h0;
    end else if (acc) begin
      ch <= (ch == ChW'(CHANNELS - 1)) ? '0 : ch + ChW'(1);
      if (is0) begin
        key_active <= key_now;
        prev_time  <= time_ms;
        seq        <= seq + 16'd1;
        if (key_interval == 16'h0 || rec_inc >= {1'b0, key_interval}) rec_cnt <= 16'h0;
        else rec_cnt <= rec_inc[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      jobs[0] <= job0;
      for (int i = 1; i <= LAST; i++) jobs[i] <= jobs[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], acc};
    end
  end

  lfde_sample_mem #(
    .DEPTH(CHANNELS),
    .AW(ChW)
  ) u_mem (
    .clk  (clk),
    .rst  (rst),
    .rd_en(adv),
    .wr_en(acc),
    .addr (ch),
    .wdata(sample_bits),
    .rdata(prev_sample)
  );

  lfde_quant u_quant (
    .clk  (clk),
    .en   (adv),
    .cur  (jobs[0].sample),
    .prev (prev_sample),
    .scale(delta_scale_bits),
    .q    (q)
  );

  lfde_framer u_framer (
    .clk            (clk),
    .rst            (rst),
    .job_valid      (vld[LAST]),
    .job            (jobs[LAST]),
    .q              (q),
    .magic_first    (magic_first),
    .magic_second   (magic_second),
    .key_type_code  (key_type_code),
    .delta_type_code(delta_type_code),
    .take           (take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .frame_byte     (frame_byte),
    .frame_end      (frame_end)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> vld[LAST])
    else $error("input stalled with free pipeline");

  a_ch_range: assert property (@(posedge clk) disable iff (rst)
    !(ch > ChW'(CHANNELS - 1)))
    else $error("channel index out of range");

  a_key_payload: assert property (@(posedge clk) disable iff (rst)
    vld[0] && jobs[0].key |-> jobs[0].pl)
    else $error("key frame beat without payload");

endmodule
